// File: rtl/core/ipra_pkg.sv
// Shared constants and codes for the IOVA page-run allocator.
// Used by iova_page_run_allocator; depends on nothing.
package ipra_pkg;

  localparam int REGION_PAGES    = 4096;
  localparam int REGIONS         = 8;
  localparam int MAX_ALIGN_ORDER = 8;

  localparam int TOTAL_PAGES = REGIONS * REGION_PAGES;
  localparam int WORD_BITS   = 64;
  localparam int MAP_WORDS   = TOTAL_PAGES / WORD_BITS;
  localparam int WADDR_W     = $clog2(MAP_WORDS);
  localparam int RP_W        = $clog2(REGION_PAGES);
  // page positions, wide enough to hold TOTAL_PAGES itself
  localparam int PAGE_W      = $clog2(TOTAL_PAGES) + 1;
  localparam int BIT_W       = $clog2(WORD_BITS);

  localparam int IOVA_W  = 52;
  localparam int COUNT_W = 16;
  localparam int LIMIT_W = 4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;

  localparam logic [1:0] CFG_BASE_PAGE    = 2'd0;
  localparam logic [1:0] CFG_REGION_LIMIT = 2'd1;

endpackage

// File: rtl/core/iova_page_run_allocator.sv
// IOVA page-run allocator: occupancy bitmap in a 64-bit-wide RAM and a
// sequencer that scans and updates it one word at a time.
// Depends on ipra_pkg.
//
// Usage:
//  - in_* channel carries one request: tuser = op, tdata = page_number and
//    page_count. out_* channel returns one response per request: tuser =
//    status, tdata = result_page. cfg_* writes base_page (index 0) and
//    region_limit (index 1); cfg_ready is always high, write only when idle.
//  - After reset a clearing pass zeroes all MAP_WORDS (512) bitmap words,
//    one word per cycle; in_tready is high only while the sequencer idles.
//  - Allocate: a check step per candidate start, a RAM read then a mask and
//    top-hit search per bitmap word, a read and a write per word of the marked
//    run, then a response load. A pass can cover all 8 regions; in a fragmented
//    map each aligned candidate that meets a busy page repeats check and search.
//  - Free/reserve: check steps S_PREP1 and S_PREP2, a read-modify-write per
//    word, then a response load; a bad op, zero count or oversize allocate
//    goes straight to the response load.
//  - Response waits in an output register; a new request is taken meanwhile,
//    and the next response is held (input stalled) until the register drains.
module iova_page_run_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [51:0] page_number, [67:52] page_count, pad
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [51:0] result_page, pad
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [51:0] cfg_data
);

  localparam int PW = ipra_pkg::PAGE_W;
  localparam int AW = ipra_pkg::WADDR_W;
  localparam int IW = ipra_pkg::IOVA_W;
  localparam int CW = ipra_pkg::COUNT_W;
  localparam int MW = ipra_pkg::MAX_ALIGN_ORDER;
  localparam int BW = ipra_pkg::BIT_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PREP1, S_PREP2, S_CHECK, S_SRD, S_SEV, S_WRD, S_WWR, S_DONE
  } state_t;

  state_t            state_r;
  logic [AW-1:0]     clr_cnt_r;
  logic [IW-1:0]     base_r;
  logic [ipra_pkg::LIMIT_W-1:0] limit_r;
  logic [1:0]        op_r;
  logic [IW-1:0]     pn_r;
  logic [CW-1:0]     cnt_r;
  logic [IW-1:0]     off_r;
  logic              below_r;
  logic [MW-1:0]     amask_r;
  logic [PW-1:0]     pos_r;
  logic [AW-1:0]     word_r;
  logic [PW-1:0]     wa_r, we_r;
  ipra_pkg::status_t st_r;
  logic [IW-1:0]     page_r;
  logic              out_valid_r;
  ipra_pkg::status_t out_status_r;
  logic [IW-1:0]     out_page_r;

  // bitmap RAM
  logic [ipra_pkg::WORD_BITS-1:0] mem [ipra_pkg::MAP_WORDS];
  logic [ipra_pkg::WORD_BITS-1:0] rdata_r;
  logic [ipra_pkg::WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]                  mem_addr;
  logic                           mem_rd, mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_rd) rdata_r <= mem[mem_addr];
  end

  // bits of word w that fall inside [a, e)
  function automatic logic [ipra_pkg::WORD_BITS-1:0] word_mask(
      input logic [AW-1:0] w, input logic [PW-1:0] a, input logic [PW-1:0] e);
    logic [PW-1:0] e1;
    logic [BW-1:0] lo, hi;
    logic [ipra_pkg::WORD_BITS-1:0] m;
    e1 = e - PW'(1);
    lo = (w == a[PW-2:BW])  ? a[BW-1:0]  : '0;
    hi = (w == e1[PW-2:BW]) ? e1[BW-1:0] : '1;
    for (int j = 0; j < ipra_pkg::WORD_BITS; j++)
      m[j] = (BW'(j) >= lo) && (BW'(j) <= hi);
    return m;
  endfunction

  function automatic logic [BW-1:0] top_bit(input logic [ipra_pkg::WORD_BITS-1:0] v);
    logic [BW-1:0] p;
    p = '0;
    for (int j = 0; j < ipra_pkg::WORD_BITS; j++)
      if (v[j]) p = BW'(j);
    return p;
  endfunction

  // end of usable space in pages
  logic [PW-1:0] lim_end;
  always_comb begin
    if (32'(limit_r) > ipra_pkg::REGIONS) lim_end = PW'(ipra_pkg::TOTAL_PAGES);
    else lim_end = PW'(limit_r) << ipra_pkg::RP_W;
  end

  // input unpack
  logic [IW-1:0] in_pn;
  logic [CW-1:0] in_cnt;
  logic [CW-1:0] in_cm1;
  logic [MW-1:0] smear;
  assign in_pn  = in_tdata[IW-1:0];
  assign in_cnt = in_tdata[IW+CW-1:IW];
  assign in_cm1 = in_cnt - CW'(1);
  always_comb begin
    smear = in_cm1[MW-1:0];
    for (int k = 1; k < MW; k++) smear = smear | (smear >> 1);
  end

  // scan / write datapath
  logic [PW-1:0]  run_end, last_pg, hit_pos, nxt_region;
  logic [ipra_pkg::WORD_BITS-1:0] cur_mask, hits;
  logic [PW:0]    in_reg_sum;
  logic           last_word;
  always_comb begin
    run_end    = pos_r + PW'(cnt_r);
    cur_mask   = (state_r == S_SEV) ? word_mask(word_r, pos_r, run_end)
                                    : word_mask(word_r, wa_r, we_r);
    hits       = rdata_r & cur_mask;
    hit_pos    = (PW'({word_r, top_bit(hits)}) + PW'(1) + PW'(amask_r)) & ~PW'(amask_r);
    last_pg    = ((state_r == S_SEV) ? run_end : we_r) - PW'(1);
    last_word  = (word_r == last_pg[PW-2:BW]);
    in_reg_sum = (PW+1)'(pos_r[ipra_pkg::RP_W-1:0]) + (PW+1)'(cnt_r);
    nxt_region = (pos_r | PW'(ipra_pkg::REGION_PAGES - 1)) + PW'(1);
  end

  logic [IW:0] res_end;
  logic [CW:0] free_end;
  assign res_end  = {1'b0, off_r} + (IW+1)'(cnt_r);
  assign free_end = (CW+1)'(off_r[ipra_pkg::RP_W-1:0]) + (CW+1)'(cnt_r);

  always_comb begin
    mem_rd    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = word_r;
    mem_wdata = (op_r == ipra_pkg::OP_FREE) ? (rdata_r & ~cur_mask) : (rdata_r | cur_mask);
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
      end
      S_SRD, S_WRD: mem_rd = 1'b1;
      S_WWR:        mem_we = 1'b1;
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0, out_page_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      base_r      <= '0;
      limit_r     <= ipra_pkg::LIMIT_W'(8);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == ipra_pkg::CFG_BASE_PAGE)    base_r  <= cfg_data;
        if (cfg_index == ipra_pkg::CFG_REGION_LIMIT) limit_r <= cfg_data[ipra_pkg::LIMIT_W-1:0];
      end
      // S_DONE reloads the register itself
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (&clr_cnt_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser;
            pn_r    <= in_pn;
            cnt_r   <= in_cnt;
            amask_r <= (in_cnt > CW'(1 << MW)) ? '1 : smear;
            pos_r   <= '0;
            page_r  <= '0;
            if (in_cnt == '0 || !(in_tuser == ipra_pkg::OP_ALLOC ||
                in_tuser == ipra_pkg::OP_FREE || in_tuser == ipra_pkg::OP_RESERVE)) begin
              st_r    <= ipra_pkg::ST_INVALID;
              state_r <= S_DONE;
            end else if (in_tuser == ipra_pkg::OP_ALLOC) begin
              if (in_cnt > CW'(ipra_pkg::REGION_PAGES)) begin
                st_r    <= ipra_pkg::ST_NOSPACE;
                state_r <= S_DONE;
              end else begin
                state_r <= S_CHECK;
              end
            end else begin
              state_r <= S_PREP1;
            end
          end
        end
        S_PREP1: begin
          off_r   <= pn_r - base_r;
          below_r <= pn_r < base_r;
          state_r <= S_PREP2;
        end
        S_PREP2: begin
          wa_r   <= off_r[PW-1:0];
          we_r   <= off_r[PW-1:0] + PW'(cnt_r);
          word_r <= off_r[PW-2:BW];
          st_r   <= ipra_pkg::ST_OK;
          if (below_r ||
              ((op_r == ipra_pkg::OP_RESERVE) && (res_end > (IW+1)'(lim_end))) ||
              ((op_r == ipra_pkg::OP_FREE) && ((off_r >= IW'(lim_end)) ||
               (free_end > (CW+1)'(ipra_pkg::REGION_PAGES))))) begin
            st_r    <= ipra_pkg::ST_INVALID;
            state_r <= S_DONE;
          end else begin
            state_r <= S_WRD;
          end
        end
        S_CHECK: begin
          if (pos_r >= lim_end) begin
            st_r    <= ipra_pkg::ST_NOSPACE;
            state_r <= S_DONE;
          end else if (in_reg_sum > (PW+1)'(ipra_pkg::REGION_PAGES)) begin
            pos_r <= nxt_region;  // run would leave its region
          end else begin
            word_r  <= pos_r[PW-2:BW];
            state_r <= S_SRD;
          end
        end
        S_SRD: state_r <= S_SEV;
        S_SEV: begin
          if (hits != '0) begin
            pos_r   <= hit_pos;   // skip past the highest busy page in range
            state_r <= S_CHECK;
          end else if (last_word) begin
            wa_r    <= pos_r;
            we_r    <= run_end;
            word_r  <= pos_r[PW-2:BW];
            st_r    <= ipra_pkg::ST_OK;
            page_r  <= base_r + IW'(pos_r);
            state_r <= S_WRD;
          end else begin
            word_r  <= word_r + AW'(1);
            state_r <= S_SRD;
          end
        end
        S_WRD: state_r <= S_WWR;
        S_WWR: begin
          if (last_word) state_r <= S_DONE;
          else begin
            word_r  <= word_r + AW'(1);
            state_r <= S_WRD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_page_r   <= page_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // no RAM write outside clearing and run updates
  a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_WWR))
    else $error("bitmap written outside a write step");

  // nothing accepted before the clearing pass ends
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("request accepted during clearing pass");

  // a page is returned only with an ok status
  a_page_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ipra_pkg::ST_OK) |-> (out_page_r == '0))
    else $error("nonzero page on failed request");

  // scan candidate stays inside the map
  a_scan_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEV) |-> (pos_r < PW'(ipra_pkg::TOTAL_PAGES)))
    else $error("scan position past end of map");

endmodule
